// ===== sv/gbb_pkg.sv =====
// Package for the glyph row bit blitter: constants, item types and the queued job type.
`default_nettype none
package gbb_pkg;

    // Framebuffer geometry and glyph limits.
    localparam int FB_WIDTH        = 128;
    localparam int FB_HEIGHT       = 64;
    localparam int MAX_GLYPH_WIDTH = 32;
    localparam int FB_BYTES        = FB_WIDTH / 8;

    // Field widths fixed by the item formats.
    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 32;
    localparam int ADDR_W   = 10;
    localparam int SH_W     = ROW_W + BYTE_W;
    localparam int CHK_W    = 12;
    localparam int MAX_BYTES = (BYTE_W - 1 + ROW_W + BYTE_W - 1) / BYTE_W;
    localparam int NB_W     = $clog2(MAX_BYTES + 1);

    // Queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] KEEP_ALL = 8'hff;

    typedef struct packed {
        logic [7:0]       x_pos;
        logic [6:0]       y_pos;
        logic [5:0]       glyph_width;
        logic [6:0]       glyph_height;
        logic [5:0]       row_index;
        logic [ROW_W-1:0] row_bits;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] keep_mask;
        logic              out_of_bounds;
        logic              last_write;
    } t_out_item;

    // One classified glyph row, ready for the write sequencer.
    typedef struct packed {
        logic              bad;
        logic [NB_W-1:0]   nbytes;
        logic [ADDR_W-1:0] base;
        logic [SH_W-1:0]   data;
        logic [SH_W-1:0]   mask;
    } t_job;

endpackage
`default_nettype wire

// ===== sv/gbb_front.sv =====
// Front end: checks bounds and aligns one glyph row into a byte-write job.
`default_nettype none
module gbb_front (
    input  var gbb_pkg::t_in_item i_item,
    output var gbb_pkg::t_job     o_job
);
    import gbb_pkg::*;

    logic [CHK_W-1:0]  x_ext, y_ext, w_ext, h_ext, row_ext;
    logic              bad;
    logic [7:0]        x0;
    logic [7:0]        y0;
    logic [2:0]        off;
    logic [ROW_W-1:0]  span;
    logic [6:0]        nb_sum;
    logic [ADDR_W-1:0] base;

    always_comb begin
        x_ext   = CHK_W'(i_item.x_pos);
        y_ext   = CHK_W'(i_item.y_pos);
        w_ext   = CHK_W'(i_item.glyph_width);
        h_ext   = CHK_W'(i_item.glyph_height);
        row_ext = CHK_W'(i_item.row_index);

        bad = (x_ext == '0) || (y_ext == '0) || (w_ext == '0) || (h_ext == '0)
            || (w_ext > CHK_W'(MAX_GLYPH_WIDTH)) || (w_ext > CHK_W'(ROW_W))
            || (row_ext >= h_ext)
            || (x_ext + w_ext > CHK_W'(FB_WIDTH + 1))
            || (y_ext + h_ext > CHK_W'(FB_HEIGHT + 1));

        x0  = i_item.x_pos - 8'd1;
        y0  = 8'(i_item.y_pos) - 8'd1 + 8'(i_item.row_index);
        off = x0[2:0];

        // Left-aligned run of glyph_width ones.
        span = ~({ROW_W{1'b1}} >> i_item.glyph_width);

        nb_sum = 7'(off) + 7'(i_item.glyph_width) + 7'd7;
        base   = ADDR_W'(y0) * ADDR_W'(FB_BYTES) + ADDR_W'(x0[7:3]);

        o_job.bad    = bad;
        o_job.nbytes = bad ? NB_W'(1) : NB_W'(nb_sum >> 3);
        o_job.base   = base;
        o_job.data   = SH_W'(i_item.row_bits & span) << (4'd8 - 4'(off));
        o_job.mask   = SH_W'(span) << (4'd8 - 4'(off));
    end

endmodule
`default_nettype wire

// ===== sv/gbb_queue.sv =====
// Short queue of classified jobs between the front end and the write sequencer.
`default_nettype none
module gbb_queue (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_push,
    input  var gbb_pkg::t_job i_job,
    output var logic          o_full,
    input  var logic          i_pop,
    output var logic          o_valid,
    output var gbb_pkg::t_job o_job
);
    import gbb_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push, pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== sv/gbb_back.sv =====
// Write sequencer: walks the bytes of the head job into the output register.
`default_nettype none
module gbb_back (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_q_valid,
    input  var gbb_pkg::t_job     i_job,
    output var logic              o_pop,
    output var logic              o_valid,
    output var gbb_pkg::t_out_item o_item,
    input  var logic              i_stall
);
    import gbb_pkg::*;

    logic [NB_W-1:0] r_k, n_k;
    logic            r_valid, n_valid;
    t_out_item       r_item;
    t_out_item       res;
    logic            adv, emit, last;

    assign adv  = !r_valid || !i_stall;
    assign emit = adv && i_q_valid;
    assign last = (NB_W'(r_k + 1'b1) == i_job.nbytes);
    assign o_pop = emit && last;

    always_comb begin
        if (i_job.bad) begin
            res.byte_address  = '0;
            res.write_data    = '0;
            res.keep_mask     = KEEP_ALL;
            res.out_of_bounds = 1'b1;
            res.last_write    = 1'b1;
        end else begin
            res.byte_address  = i_job.base + ADDR_W'(r_k);
            res.write_data    = BYTE_W'(i_job.data >> (ROW_W - BYTE_W * int'(r_k)));
            res.keep_mask     = ~BYTE_W'(i_job.mask >> (ROW_W - BYTE_W * int'(r_k)));
            res.out_of_bounds = 1'b0;
            res.last_write    = last;
        end
    end

    always_comb begin
        n_k     = r_k;
        n_valid = r_valid;
        if (adv) begin
            n_valid = i_q_valid;
        end
        if (emit) begin
            n_k = last ? '0 : NB_W'(r_k + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_k     <= n_k;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_item <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== sv/glyph_row_bit_blitter.sv =====
// Top level of the glyph row bit blitter for a 1-bit-per-pixel framebuffer.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+--------------------------
//   input   | in        | i_valid / o_stall  | i_item  (gbb_pkg::t_in_item)
//   result  | out       | o_valid / i_stall  | o_item  (gbb_pkg::t_out_item)
//
// Each item is one glyph row. It is classified and aligned in the same cycle
// it is accepted and enters a two-entry job queue. The write sequencer then
// sends one result per cycle while i_stall is low: one for a rejected item,
// otherwise one to five masked byte writes. The input is stalled only while
// the job queue is full; the output register holds its item while i_stall
// is high. Reset empties the queue and the output register.
`default_nettype none
module glyph_row_bit_blitter (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_valid,
    input  var gbb_pkg::t_in_item   i_item,
    output var logic                o_stall,
    output var logic                o_valid,
    output var gbb_pkg::t_out_item  o_item,
    input  var logic                i_stall
);
    import gbb_pkg::*;

    t_job front_job;
    t_job head_job;
    logic q_full;
    logic q_valid;
    logic q_pop;

    // The front end is purely combinational: bound checks, span mask, shift
    // into byte lanes, start address and byte count.
    gbb_front u_front (
        .i_item (i_item),
        .o_job  (front_job)
    );

    // The queue decouples accepting items from the per-byte write sequence.
    gbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // The back end emits the head job's bytes in address order and pops the
    // job together with its last write.
    gbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_item    (o_item),
        .i_stall   (i_stall)
    );

    assign o_stall = q_full;

endmodule
`default_nettype wire
